### rtl/core/lfbr_pkg.sv
// Shared types and constants for the length framed byte receiver.
// No dependencies; used by lfbr_frame_ctl and length_framed_byte_receiver_top.
package lfbr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned FlenW   = 13;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_MARKER   = 2'd1;

  localparam logic [ByteW-1:0] START_MARKER_RST = 8'h53;
  localparam logic [ByteW-1:0] END_MARKER_RST   = 8'h45;

  // outcome codes
  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_COMMIT = 2'd1;
  localparam logic [1:0] OUT_ERROR  = 2'd2;

  typedef struct packed {
    logic              ack_valid;
    logic [ByteW-1:0]  ack_byte;
    logic              store_valid;
    logic [IndexW-1:0] store_index;
    logic [ByteW-1:0]  store_byte;
    logic [1:0]        outcome;
    logic [FlenW-1:0]  frame_length;
  } result_t;

endpackage

### rtl/core/lfbr_frame_ctl.sv
// Frame parser: phase, expected length and payload count, plus per-byte result.
// Depends on lfbr_pkg.
module lfbr_frame_ctl #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [lfbr_pkg::ByteW-1:0]  byte_i,
  input  logic [lfbr_pkg::ByteW-1:0]  start_marker_i,
  input  logic [lfbr_pkg::ByteW-1:0]  end_marker_i,
  output lfbr_pkg::result_t           res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CmpW = lfbr_pkg::LenW + 1;
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(BUFFER_DEPTH);

  localparam logic [2:0] PH_WAIT_START = 3'd0;
  localparam logic [2:0] PH_LEN_HI     = 3'd1;
  localparam logic [2:0] PH_LEN_LO     = 3'd2;
  localparam logic [2:0] PH_DATA       = 3'd3;
  localparam logic [2:0] PH_WAIT_END   = 3'd4;
  localparam logic [2:0] PH_HALTED     = 3'd5;

  logic [2:0]                 phase_q, phase_d;
  logic [lfbr_pkg::LenW-1:0]  exp_len_q, exp_len_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            count_inc;

  assign count_inc = count_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    res_o     = '0;
    unique case (phase_q)
      PH_WAIT_START: begin
        if (byte_i == start_marker_i) begin
          res_o.ack_valid = 1'b1;
          phase_d         = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        res_o.ack_valid = 1'b1;
        exp_len_d       = {byte_i, 8'h00};
        phase_d         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res_o.ack_valid = 1'b1;
        exp_len_d       = {exp_len_q[15:8], byte_i};
        count_d         = '0;
        if (CmpW'(exp_len_d) > DepthCmp) begin
          res_o.outcome = lfbr_pkg::OUT_ERROR;
          phase_d       = PH_HALTED;
        end else if (exp_len_d == '0) begin
          phase_d = PH_WAIT_END;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res_o.ack_valid   = 1'b1;
        res_o.store_valid = 1'b1;
        res_o.store_index = lfbr_pkg::IndexW'(count_q);
        res_o.store_byte  = byte_i;
        count_d           = count_inc;
        if (CmpW'(count_inc) >= CmpW'(exp_len_q)) begin
          phase_d = PH_WAIT_END;
        end
      end
      PH_WAIT_END: begin
        if (byte_i == end_marker_i) begin
          res_o.ack_valid    = 1'b1;
          res_o.outcome      = lfbr_pkg::OUT_COMMIT;
          res_o.frame_length = lfbr_pkg::FlenW'(count_q);
        end else begin
          res_o.outcome = lfbr_pkg::OUT_ERROR;
        end
        phase_d = PH_HALTED;
      end
      PH_HALTED: ;
      default: phase_d = PH_HALTED;
    endcase
    if (res_o.ack_valid) begin
      res_o.ack_byte = byte_i + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_START;
      exp_len_q <= '0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
    end
  end

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALTED |-> res_o == '0)
    else $error("halted parser produced a result");

  a_store_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.store_valid |-> res_o.ack_valid)
    else $error("payload byte without acknowledge");

  a_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.outcome != lfbr_pkg::OUT_NONE |=> phase_q == PH_HALTED)
    else $error("frame outcome did not halt parser");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_DATA |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("payload count did not advance");

endmodule

### rtl/core/length_framed_byte_receiver_top.sv
// Length framed byte receiver, top level: input register, parser, result register.
// Depends on lfbr_pkg and lfbr_frame_ctl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received byte
//   per transfer. Output channel (out_valid_o / out_stall_i) gives exactly one
//   result per byte: acknowledge byte, payload staging byte and index, outcome
//   and committed frame length.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the start marker (index 0)
//   or end marker (index 1); other indexes are ignored. Write only while idle.
//   An accepted byte is parsed from the input register into the result register.
//   Throughput: one byte per cycle while the output is not stalled, set by the
//   single input register to result register stage.
//   Reset: parser waits for the start marker, markers return to 'S' and 'E',
//   both register stages empty. After a commit or error the block ignores bytes
//   (all-zero results) until reset.
//   Output stall holds the result register; the input register then fills and
//   in_stall_o rises in the same cycle the stall blocks the transfer.
module length_framed_byte_receiver_top #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lfbr_pkg::ByteW-1:0]     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ack_valid_o,
  output logic [lfbr_pkg::ByteW-1:0]     ack_byte_o,
  output logic                           store_valid_o,
  output logic [lfbr_pkg::IndexW-1:0]    store_index_o,
  output logic [lfbr_pkg::ByteW-1:0]     store_byte_o,
  output logic [1:0]                     outcome_o,
  output logic [lfbr_pkg::FlenW-1:0]     frame_length_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfbr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lfbr_pkg::ByteW-1:0]     cfg_data_i
);

  logic                         s1_valid_q;
  logic [lfbr_pkg::ByteW-1:0]   s1_byte_q;
  logic                         out_valid_q;
  lfbr_pkg::result_t            out_res_q;
  lfbr_pkg::result_t            res;
  logic [lfbr_pkg::ByteW-1:0]   start_marker_q;
  logic [lfbr_pkg::ByteW-1:0]   end_marker_q;
  logic                         out_free;
  logic                         advance;
  logic                         in_xfer;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  lfbr_frame_ctl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame_ctl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (s1_byte_q),
    .start_marker_i(start_marker_q),
    .end_marker_i  (end_marker_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      start_marker_q <= lfbr_pkg::START_MARKER_RST;
      end_marker_q   <= lfbr_pkg::END_MARKER_RST;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          lfbr_pkg::CFG_START_MARKER: start_marker_q <= cfg_data_i;
          lfbr_pkg::CFG_END_MARKER:   end_marker_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ack_valid_o    = out_res_q.ack_valid;
  assign ack_byte_o     = out_res_q.ack_byte;
  assign store_valid_o  = out_res_q.store_valid;
  assign store_index_o  = out_res_q.store_index;
  assign store_byte_o   = out_res_q.store_byte;
  assign outcome_o      = out_res_q.outcome;
  assign frame_length_o = out_res_q.frame_length;

endmodule

### sim/lfbr_result_checker.sv
// Result checker for the length framed byte receiver: predicts one result per
// accepted byte and compares it with the output channel. Depends on lfbr_pkg.
`timescale 1ns / 100ps

module lfbr_result_checker #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [lfbr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         ack_valid_i,
  input  logic [lfbr_pkg::ByteW-1:0]   ack_byte_i,
  input  logic                         store_valid_i,
  input  logic [lfbr_pkg::IndexW-1:0]  store_index_i,
  input  logic [lfbr_pkg::ByteW-1:0]   store_byte_i,
  input  logic [1:0]                   outcome_i,
  input  logic [lfbr_pkg::FlenW-1:0]   frame_length_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [lfbr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lfbr_pkg::ByteW-1:0]   cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);

  typedef enum logic [2:0] {
    RX_WAIT_START,
    RX_LEN_HI,
    RX_LEN_LO,
    RX_DATA,
    RX_WAIT_END,
    RX_HALTED
  } rx_phase_e;

  rx_phase_e                  phase;
  logic [lfbr_pkg::ByteW-1:0] start_mark;
  logic [lfbr_pkg::ByteW-1:0] end_mark;
  logic [lfbr_pkg::LenW-1:0]  want_len;
  logic [lfbr_pkg::FlenW-1:0] rx_count;

  lfbr_pkg::result_t byte_results_q[$];
  lfbr_pkg::result_t want;
  lfbr_pkg::result_t got;
  int                fails;
  int                results_seen;

  function automatic lfbr_pkg::result_t parse_byte(input logic [lfbr_pkg::ByteW-1:0] b);
    lfbr_pkg::result_t r;
    r = '0;
    case (phase)
      RX_WAIT_START: begin
        if (b == start_mark) begin
          r.ack_valid = 1'b1;
          phase = RX_LEN_HI;
        end
      end
      RX_LEN_HI: begin
        r.ack_valid = 1'b1;
        want_len = {b, 8'h00};
        phase = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        r.ack_valid = 1'b1;
        want_len[7:0] = b;
        rx_count = '0;
        if (32'(want_len) > BUFFER_DEPTH) begin
          r.outcome = lfbr_pkg::OUT_ERROR;
          phase = RX_HALTED;
        end else if (want_len == '0) begin
          phase = RX_WAIT_END;
        end else begin
          phase = RX_DATA;
        end
      end
      RX_DATA: begin
        r.ack_valid   = 1'b1;
        r.store_valid = 1'b1;
        r.store_index = rx_count[lfbr_pkg::IndexW-1:0];
        r.store_byte  = b;
        rx_count = rx_count + 1'b1;
        if (lfbr_pkg::LenW'(rx_count) >= want_len) begin
          phase = RX_WAIT_END;
        end
      end
      RX_WAIT_END: begin
        if (b == end_mark) begin
          r.ack_valid    = 1'b1;
          r.outcome      = lfbr_pkg::OUT_COMMIT;
          r.frame_length = rx_count;
        end else begin
          r.outcome = lfbr_pkg::OUT_ERROR;
        end
        phase = RX_HALTED;
      end
      default: begin
        phase = RX_HALTED;
      end
    endcase
    if (r.ack_valid) begin
      r.ack_byte = b + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase        = RX_WAIT_START;
      start_mark   = lfbr_pkg::START_MARKER_RST;
      end_mark     = lfbr_pkg::END_MARKER_RST;
      want_len     = '0;
      rx_count     = '0;
      fails        = 0;
      results_seen = 0;
      byte_results_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.ack_valid    = ack_valid_i;
        got.ack_byte     = ack_byte_i;
        got.store_valid  = store_valid_i;
        got.store_index  = store_index_i;
        got.store_byte   = store_byte_i;
        got.outcome      = outcome_i;
        got.frame_length = frame_length_i;
        if (byte_results_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: result transfer %0d with no byte outstanding", $time,
                     results_seen);
          end
        end else begin
          want = byte_results_q.pop_front();
          if (want.ack_valid !== got.ack_valid || want.ack_byte !== got.ack_byte ||
              want.store_valid !== got.store_valid ||
              want.store_index !== got.store_index ||
              want.store_byte !== got.store_byte || want.outcome !== got.outcome ||
              want.frame_length !== got.frame_length) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result %0d mismatch", $time, results_seen);
              $display("  exp ack=%b/%h store=%b/%0d/%h outcome=%0d len=%0d",
                       want.ack_valid, want.ack_byte, want.store_valid,
                       want.store_index, want.store_byte, want.outcome,
                       want.frame_length);
              $display("  got ack=%b/%h store=%b/%0d/%h outcome=%0d len=%0d",
                       got.ack_valid, got.ack_byte, got.store_valid,
                       got.store_index, got.store_byte, got.outcome,
                       got.frame_length);
            end
          end
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lfbr_pkg::CFG_START_MARKER: start_mark = cfg_data_i;
          lfbr_pkg::CFG_END_MARKER:   end_mark = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        byte_results_q.push_back(parse_byte(rx_byte_i));
      end
      mismatches_o <= fails;
      pending_o    <= byte_results_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for length_framed_byte_receiver_top: clock, reset, byte and
// marker stimulus, output stall, watchdog and verdict. Uses lfbr_result_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned BUFFER_DEPTH = 4096;
  localparam int unsigned ITEMS        = 700;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;

  // indexes past the register list, writes must be dropped
  localparam logic [lfbr_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [lfbr_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {FR_COMMIT, FR_BAD_END, FR_EMPTY, FR_OVERSIZE} frame_kind_e;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [lfbr_pkg::ByteW-1:0]   rx_byte;
  logic                         out_valid;
  logic                         out_stall;
  logic                         ack_valid;
  logic [lfbr_pkg::ByteW-1:0]   ack_byte;
  logic                         store_valid;
  logic [lfbr_pkg::IndexW-1:0]  store_index;
  logic [lfbr_pkg::ByteW-1:0]   store_byte;
  logic [1:0]                   outcome;
  logic [lfbr_pkg::FlenW-1:0]   frame_length;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lfbr_pkg::CfgIdxW-1:0] cfg_index;
  logic [lfbr_pkg::ByteW-1:0]   cfg_data;

  int          mismatches;
  int          pending;
  int unsigned n_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles = 0;
  logic        hold_armed;
  logic        hold_taken;

  length_framed_byte_receiver_top #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .ack_valid_o   (ack_valid),
    .ack_byte_o    (ack_byte),
    .store_valid_o (store_valid),
    .store_index_o (store_index),
    .store_byte_o  (store_byte),
    .outcome_o     (outcome),
    .frame_length_o(frame_length),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  lfbr_result_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .ack_valid_i   (ack_valid),
    .ack_byte_i    (ack_byte),
    .store_valid_i (store_valid),
    .store_index_i (store_index),
    .store_byte_i  (store_byte),
    .outcome_i     (outcome),
    .frame_length_i(frame_length),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** length_framed_byte_receiver_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: short runs and stalls, occasional long ones, one long hold-off
  initial begin : rx_stall
    int unsigned run_len;
    int unsigned stall_len;
    int unsigned r;
    out_stall  = 1'b0;
    hold_taken = 1'b0;
    wait (rst_n);
    forever begin
      r = $urandom_range(0, 99);
      run_len = (r < 85) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_armed && !hold_taken) begin
        stall_len = HOLD_CYCLES;
        hold_taken <= 1'b1;
      end else if (r < 35) begin
        stall_len = 0;
      end else if (r < 90) begin
        stall_len = $urandom_range(1, 3);
      end else if (r < 98) begin
        stall_len = $urandom_range(4, 12);
      end else begin
        stall_len = $urandom_range(20, 40);
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  task automatic sender_gap(output int unsigned g);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left != 0) begin
      burst_left--;
      g = 0;
    end else if (r < 45) begin
      g = 0;
    end else if (r < 80) begin
      g = $urandom_range(1, 3);
    end else if (r < 95) begin
      g = $urandom_range(4, 10);
    end else if (r < 98) begin
      g = $urandom_range(20, 40);
    end else begin
      burst_left = $urandom_range(20, 60);
      g = 0;
    end
  endtask

  task automatic send_byte(input logic [lfbr_pkg::ByteW-1:0] b);
    int unsigned g;
    sender_gap(g);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // wait until every byte sent has its result back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [lfbr_pkg::CfgIdxW-1:0] idx,
                           input logic [lfbr_pkg::ByteW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin : stimulus
    frame_kind_e                kind;
    logic [lfbr_pkg::ByteW-1:0] start_mk;
    logic [lfbr_pkg::ByteW-1:0] end_mk;
    logic [lfbr_pkg::ByteW-1:0] b;
    int unsigned                len;
    int unsigned                r;
    int unsigned                k;
    int unsigned                target;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = lfbr_pkg::CFG_START_MARKER;
    cfg_data     = '0;
    hold_armed   = 1'b0;
    n_sent       = 0;
    burst_left   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // reset markers: only 'S' opens a frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h52);
    send_byte(8'h54);
    send_byte(8'h45);
    send_byte(8'hAA);
    send_byte(8'h55);

    drain();
    cfg_write(lfbr_pkg::CFG_START_MARKER, 8'h00);
    cfg_write(lfbr_pkg::CFG_END_MARKER, 8'hFF);
    cfg_write(CFG_SPARE_LO, 8'hFF);
    cfg_write(CFG_SPARE_HI, 8'h00);
    cfg_valid <= 1'b0;
    send_byte(8'h53);
    send_byte(8'hFF);
    send_byte(8'h01);

    drain();
    cfg_write(lfbr_pkg::CFG_START_MARKER, 8'hFF);
    cfg_valid <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h53);

    // the one frame of the run, then everything after it is ignored
    start_mk = 8'($urandom);
    end_mk   = 8'($urandom);
    drain();
    cfg_write(lfbr_pkg::CFG_START_MARKER, start_mk);
    cfg_write(lfbr_pkg::CFG_END_MARKER, end_mk);
    cfg_valid <= 1'b0;
    k = $urandom_range(0, 40);
    repeat (k) begin
      b = 8'($urandom);
      while (b == start_mk) b = 8'($urandom);
      send_byte(b);
    end

    r = $urandom_range(0, 99);
    if (r < 55) kind = FR_COMMIT;
    else if (r < 75) kind = FR_BAD_END;
    else if (r < 85) kind = FR_EMPTY;
    else kind = FR_OVERSIZE;
    r = $urandom_range(0, 99);
    case (kind)
      FR_COMMIT: begin
        if (r < 15) len = $urandom_range(600, 650);
        else if (r < 25) len = 1;
        else len = $urandom_range(2, 650);
      end
      FR_BAD_END: len = $urandom_range(1, 400);
      FR_EMPTY:   len = 0;
      default: begin
        if (r < 40) len = BUFFER_DEPTH + 1;
        else if (r < 60) len = 16'hFFFF;
        else len = $urandom_range(BUFFER_DEPTH + 2, 65534);
      end
    endcase
    if (kind != FR_OVERSIZE && len >= 200) hold_armed <= 1'b1;

    send_byte(start_mk);
    send_byte(8'(len >> 8));
    send_byte(8'(len));
    if (kind != FR_OVERSIZE) begin
      for (int unsigned i = 0; i < len; i++) begin
        if (i == 0) b = 8'h00;
        else if (i == 1) b = 8'hFF;
        else b = 8'($urandom);
        send_byte(b);
      end
      // change the closing marker while the frame is still open
      drain();
      end_mk = 8'($urandom);
      cfg_write(lfbr_pkg::CFG_END_MARKER, end_mk);
      cfg_valid <= 1'b0;
      if (kind == FR_BAD_END) b = end_mk ^ 8'($urandom_range(1, 255));
      else b = end_mk;
      send_byte(b);
    end

    // halted: frames and noise alike must come back all zero
    drain();
    start_mk = 8'($urandom);
    cfg_write(lfbr_pkg::CFG_START_MARKER, start_mk);
    cfg_write(lfbr_pkg::CFG_END_MARKER, 8'h00);
    cfg_valid <= 1'b0;
    end_mk = 8'h00;
    hold_armed <= 1'b1;
    target = (n_sent + 60 > ITEMS) ? n_sent + 60 : ITEMS;
    while (n_sent < target) begin
      if ($urandom_range(0, 99) < 30) begin
        k = $urandom_range(0, 5);
        send_byte(start_mk);
        send_byte(8'h00);
        send_byte(8'(k));
        repeat (k) send_byte(8'($urandom));
        send_byte(end_mk);
      end else begin
        send_byte(8'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** length_framed_byte_receiver_top: PASSED **");
    end else begin
      $display("** length_framed_byte_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule
